FILE: src/joint_velocity_command_controller_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the joint velocity command controller
// Shared wrappers for the concurrent checks at the end of the controller RTL.
// ---------------------------------------------------------------------------
`ifndef JOINT_VELOCITY_COMMAND_CONTROLLER_UNIT_ASSERT_SVH
`define JOINT_VELOCITY_COMMAND_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JVCC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JVCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/jvcc_pkg.sv
// ---------------------------------------------------------------------------
// Joint velocity command controller package
// Beat types, command codes, register indexes and reset values.
// ---------------------------------------------------------------------------
package jvcc_pkg;

    // Command codes carried in the input beat.
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_MOVE  = 3'd1;
    localparam logic [2:0] CMD_SPEED = 3'd2;
    localparam logic [2:0] CMD_STOP  = 3'd3;
    localparam logic [2:0] CMD_MODE  = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_MIN_ANGLE  = 3'd0;
    localparam logic [2:0] REG_MAX_ANGLE  = 3'd1;
    localparam logic [2:0] REG_MAX_SPEED  = 3'd2;
    localparam logic [2:0] REG_TOLERANCE  = 3'd3;
    localparam logic [2:0] REG_STEPS_RAD  = 3'd4;
    localparam logic [2:0] REG_RAD_STEP   = 3'd5;

    // Register reset values.
    localparam logic signed [31:0] RST_MIN_ANGLE = -32'sd205887;
    localparam logic signed [31:0] RST_MAX_ANGLE = 32'sd205887;
    localparam logic [30:0]        RST_MAX_SPEED = 31'd0;
    localparam logic [30:0]        RST_TOLERANCE = 31'd328;
    localparam logic [31:0]        RST_STEPS_RAD = 32'd33374089;
    localparam logic [31:0]        RST_RAD_STEP  = 32'd8433602;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] position_steps;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] speed_steps;
        logic signed [31:0] joint_angle;
        logic               at_min_limit;
        logic               at_max_limit;
        logic               position_mode;
    } t_out_item;

    // Request to the shared multiplier.
    typedef struct packed {
        logic               en;
        logic signed [32:0] a;
        logic signed [32:0] b;
    } t_mul_req;

endpackage

FILE: src/jvcc_mul.sv
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed 33 x 33 multiply with a registered 64-bit product.
// ---------------------------------------------------------------------------
module jvcc_mul (
    input  logic                 i_clk,
    input  jvcc_pkg::t_mul_req   i_req,
    output logic signed [63:0]   o_product
);

    logic signed [65:0] full_product;
    logic signed [63:0] r_product;

    // Operands are small enough that the upper two bits are pure sign.
    assign full_product = i_req.a * i_req.b;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_product <= full_product[63:0];
        end
    end

    assign o_product = r_product;

endmodule

FILE: src/joint_velocity_command_controller_unit.sv
// ---------------------------------------------------------------------------
// Joint velocity command controller
// Per control tick, converts the motor step position to a joint angle and
// produces a clamped, limit-aware speed command in steps per second.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Signals                               Beat
//  -------  ---------  ------------------------------------  -------------------
//  in       input      i_in_valid, o_in_ready, i_in_data     command + operands
//  out      output     o_out_valid, i_out_ready, o_out_data  one per tick
//  cfg      input      i_cfg_valid, o_cfg_ready, i_cfg_index,
//                      i_cfg_data                            register write
//
// A tick beat passes through the sequencer steps from acceptance until its
// result beat is valid, and the next input beat can be taken in that same
// cycle; the input is held while the tick is in progress. The steps are:
// the angle multiply, its rounding, the speed law, the steps multiply on the
// one shared multiplier, and the final rounding into the output register.
// Other commands are taken in the idle step and produce no result beat.
// A result that is not taken holds the sequencer in its last step, so the
// input stalls only when a second result would have nowhere to go.
// Reset is synchronous and active low; it restores the register defaults,
// clears the targets and selects speed control.
//
// Angle: position_steps * radians_per_step (Q0.32) is rounded to Q16.16 and
// saturated. Speed: in position mode, twice the error to the target with a
// deadband, else the stored target speed; both are clamped to max_speed and
// motion toward a reached limit is zeroed. The speed magnitude is scaled by
// steps_per_radian, rounded half away from zero, and the sign is restored.
// ---------------------------------------------------------------------------
`include "joint_velocity_command_controller_unit_assert.svh"

module joint_velocity_command_controller_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  jvcc_pkg::t_in_item     i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output jvcc_pkg::t_out_item    o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data
);

    // Sequencer steps of one tick.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_ANGLE,
        S_ANGLE,
        S_SPEED,
        S_MUL_STEPS,
        S_FINISH
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic signed [31:0] r_min_angle;
    logic signed [31:0] r_max_angle;
    logic [30:0]        r_max_speed;
    logic [30:0]        r_tolerance;
    logic [31:0]        r_steps_rad;
    logic [31:0]        r_rad_step;

    // Controller state.
    logic signed [31:0] r_target_angle;
    logic signed [31:0] r_target_speed;
    logic               r_mode;

    // Per-tick working registers.
    logic signed [31:0] r_pos;
    logic signed [31:0] r_angle;
    logic               r_at_min;
    logic               r_at_max;
    logic               r_neg;
    logic [30:0]        r_mag;

    // Output register.
    logic                r_out_valid;
    jvcc_pkg::t_out_item r_out;

    // Shared multiplier.
    jvcc_pkg::t_mul_req mul_req;
    logic signed [63:0] product;

    jvcc_mul u_mul (
        .i_clk     (i_clk),
        .i_req     (mul_req),
        .o_product (product)
    );

    logic in_accept;
    logic cfg_accept;

    assign in_accept  = i_in_valid && o_in_ready;
    assign cfg_accept = i_cfg_valid && o_cfg_ready;

    // The multiplier sees the step position first, then the speed magnitude.
    always_comb begin
        mul_req.en = (r_state == S_MUL_ANGLE) || (r_state == S_MUL_STEPS);
        if (r_state == S_MUL_ANGLE) begin
            mul_req.a = {r_pos[31], r_pos};
            mul_req.b = {1'b0, r_rad_step};
        end else begin
            mul_req.a = {2'b00, r_mag};
            mul_req.b = {1'b0, r_steps_rad};
        end
    end

    // Move to angle: raise to the lower limit, then lower to the upper limit,
    // so the upper limit wins when the two cross.
    logic signed [31:0] move_low;
    logic signed [31:0] n_target_angle;

    always_comb begin
        move_low       = (i_in_data.value < r_min_angle) ? r_min_angle : i_in_data.value;
        n_target_angle = (move_low > r_max_angle) ? r_max_angle : move_low;
    end

    // Clamp a signed value to plus or minus the speed limit.
    function automatic logic signed [33:0] clamp_speed(
        input logic signed [33:0] v,
        input logic [30:0]        lim
    );
        logic signed [33:0] lim_s;
        lim_s = {3'b000, lim};
        if (v > lim_s) begin
            return lim_s;
        end else if (v < -lim_s) begin
            return -lim_s;
        end else begin
            return v;
        end
    endfunction

    logic signed [31:0] n_target_speed;
    logic signed [33:0] set_speed_wide;

    assign set_speed_wide = clamp_speed({{2{i_in_data.value[31]}}, i_in_data.value},
                                        r_max_speed);
    assign n_target_speed = set_speed_wide[31:0];

    // Angle step: round the Q.32 product to Q16.16 and saturate.
    logic signed [63:0] angle_rounded;
    logic signed [47:0] angle_shifted;
    logic signed [31:0] n_angle;

    always_comb begin
        angle_rounded = product + 64'sd32768;
        angle_shifted = angle_rounded[63:16];
        if (angle_shifted > 48'sd2147483647) begin
            n_angle = 32'sh7FFF_FFFF;
        end else if (angle_shifted < -48'sd2147483648) begin
            n_angle = 32'sh8000_0000;
        end else begin
            n_angle = angle_shifted[31:0];
        end
    end

    // Speed step: error with deadband, clamp, and limit zeroing.
    logic signed [32:0] pos_err;
    logic [32:0]        abs_err;
    logic signed [33:0] speed_raw;
    logic signed [33:0] speed_lim;
    logic signed [33:0] abs_speed;

    always_comb begin
        pos_err = {r_target_angle[31], r_target_angle} - {r_angle[31], r_angle};
        abs_err = pos_err[32] ? 33'(-pos_err) : 33'(pos_err);
        if (r_mode) begin
            if (abs_err <= {2'b00, r_tolerance}) begin
                speed_raw = '0;
            end else begin
                speed_raw = clamp_speed({pos_err, 1'b0}, r_max_speed);
            end
        end else begin
            speed_raw = clamp_speed({{2{r_target_speed[31]}}, r_target_speed},
                                    r_max_speed);
        end
        if ((r_at_min && speed_raw < 0) || (r_at_max && speed_raw > 0)) begin
            speed_lim = '0;
        end else begin
            speed_lim = speed_raw;
        end
        abs_speed = speed_lim[33] ? -speed_lim : speed_lim;
    end

    // Steps step: round the magnitude half up, then restore the sign. The
    // magnitude stays below 2^31, so no saturation is needed here.
    logic [63:0] steps_rounded;
    logic [31:0] steps_mag;
    logic [31:0] n_steps;

    always_comb begin
        steps_rounded = 64'(product) + 64'h0000_0000_8000_0000;
        steps_mag     = steps_rounded[63:32];
        n_steps       = r_neg ? -steps_mag : steps_mag;
    end

    // Sequencer, configuration and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_min_angle    <= jvcc_pkg::RST_MIN_ANGLE;
            r_max_angle    <= jvcc_pkg::RST_MAX_ANGLE;
            r_max_speed    <= jvcc_pkg::RST_MAX_SPEED;
            r_tolerance    <= jvcc_pkg::RST_TOLERANCE;
            r_steps_rad    <= jvcc_pkg::RST_STEPS_RAD;
            r_rad_step     <= jvcc_pkg::RST_RAD_STEP;
            r_target_angle <= '0;
            r_target_speed <= '0;
            r_mode         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_accept) begin
                unique case (i_cfg_index)
                    jvcc_pkg::REG_MIN_ANGLE: r_min_angle <= i_cfg_data;
                    jvcc_pkg::REG_MAX_ANGLE: r_max_angle <= i_cfg_data;
                    jvcc_pkg::REG_MAX_SPEED: r_max_speed <= i_cfg_data[30:0];
                    jvcc_pkg::REG_TOLERANCE: r_tolerance <= i_cfg_data[30:0];
                    jvcc_pkg::REG_STEPS_RAD: r_steps_rad <= i_cfg_data;
                    jvcc_pkg::REG_RAD_STEP:  r_rad_step  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // In the final step the output register is handled below, where a
            // taken result is replaced by the new one in the same cycle.
            if (r_out_valid && i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        unique case (i_in_data.command)
                            jvcc_pkg::CMD_TICK: begin
                                r_pos   <= i_in_data.position_steps;
                                r_state <= S_MUL_ANGLE;
                            end
                            jvcc_pkg::CMD_MOVE: begin
                                r_target_angle <= n_target_angle;
                                r_mode         <= 1'b1;
                            end
                            jvcc_pkg::CMD_SPEED: begin
                                r_target_speed <= n_target_speed;
                                r_mode         <= 1'b0;
                            end
                            jvcc_pkg::CMD_STOP: begin
                                r_target_speed <= '0;
                            end
                            jvcc_pkg::CMD_MODE: begin
                                r_mode <= i_in_data.value[0];
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MUL_ANGLE: begin
                    r_state <= S_ANGLE;
                end
                S_ANGLE: begin
                    r_angle  <= n_angle;
                    r_at_min <= n_angle <= r_min_angle;
                    r_at_max <= n_angle >= r_max_angle;
                    r_state  <= S_SPEED;
                end
                S_SPEED: begin
                    r_neg   <= speed_lim[33];
                    r_mag   <= abs_speed[30:0];
                    r_state <= S_MUL_STEPS;
                end
                S_MUL_STEPS: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    // Wait here while an earlier result beat is still pending.
                    if (!r_out_valid || i_out_ready) begin
                        r_out.speed_steps   <= n_steps;
                        r_out.joint_angle   <= r_angle;
                        r_out.at_min_limit  <= r_at_min;
                        r_out.at_max_limit  <= r_at_max;
                        r_out.position_mode <= r_mode;
                        r_out_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A tick occupies the sequencer, so the input must close the next cycle.
    `JVCC_ASSERT_NEXT(a_tick_blocks_input, i_clk, i_rst_n, in_accept && (i_in_data.command == jvcc_pkg::CMD_TICK), !o_in_ready, "input still ready after a tick beat")
    // A new result appears only out of the last sequencer step.
    `JVCC_ASSERT_IMPL(a_result_from_finish, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_FINISH), "result beat raised outside the final step")
    // Motion toward a reached lower limit is never commanded.
    `JVCC_ASSERT_IMPL(a_no_motion_below_min, i_clk, i_rst_n, r_out_valid && r_out.at_min_limit, !r_out.speed_steps[31], "negative speed at lower limit")
    // Motion toward a reached upper limit is never commanded.
    `JVCC_ASSERT_IMPL(a_no_motion_above_max, i_clk, i_rst_n, r_out_valid && r_out.at_max_limit, r_out.speed_steps[31] || (r_out.speed_steps == 32'sd0), "positive speed at upper limit")
    // A move command always selects position control.
    `JVCC_ASSERT_NEXT(a_move_sets_mode, i_clk, i_rst_n, in_accept && (i_in_data.command == jvcc_pkg::CMD_MOVE), r_mode, "move command did not select position mode")

endmodule
